// ----- src/pqt_pkg.sv -----
// ----------------------------------------------------------------------------
// pqt_pkg
// Shared constants and types of the point-in-quad test pipeline.
// ----------------------------------------------------------------------------
package pqt_pkg;

  // default corner coordinate width, two's complement
  localparam int unsigned COORD_BITS_DEF = 13;

  // pipeline depth from accepted beat to result strobe
  localparam int unsigned LANE_STAGES = 5;
  localparam int unsigned PIPE_LAT    = LANE_STAGES + 1;

  // per-triangle compare results, registered at the last lane stage
  typedef struct packed {
    logic den_nz;   // denominator nonzero
    logic r_ok;     // 0 <= r <= 1
    logic s_ok;     // 0 <= s <= 1
    logic sum_lt;   // r + s < 1
    logic sum_eq;   // r + s == 1
  } pqt_flags_t;

endpackage

// ----- src/pqt_tri_lane.sv -----
// ----------------------------------------------------------------------------
// pqt_tri_lane
// Five-stage triangle test: edge vectors, cross products, Cramer numerators,
// sign normalization, exact rational compares.
// ----------------------------------------------------------------------------
module pqt_tri_lane
  import pqt_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] o_x,
  input  logic signed [COORD_BITS-1:0] o_y,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic        [COORD_BITS-2:0] p_x,
  input  logic        [COORD_BITS-2:0] p_y,
  output pqt_flags_t                   flags
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned NW = PW + 1;

  // stage 1: vectors relative to the origin corner
  logic signed [DW-1:0] ax_r, ay_r, bx_r, by_r, dx_r, dy_r;
  logic signed [DW-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt, dx_nxt, dy_nxt;
  // stage 2: products
  logic signed [PW-1:0] pd1_r, pd2_r, pr1_r, pr2_r, ps1_r, ps2_r;
  logic signed [PW-1:0] pd1_nxt, pd2_nxt, pr1_nxt, pr2_nxt, ps1_nxt, ps2_nxt;
  // stage 3: den, rn, sn
  logic signed [NW-1:0] den_r, rn_r, sn_r;
  logic signed [NW-1:0] den_nxt, rn_nxt, sn_nxt;
  // stage 4: normalized so den >= 0
  logic signed [NW-1:0] denp_r, rnp_r, snp_r;
  logic signed [NW-1:0] denp_nxt, rnp_nxt, snp_nxt;
  // stage 5: flags
  logic signed [NW:0]   sum;
  logic signed [NW:0]   den_x;
  pqt_flags_t           flags_r, flags_nxt;

  always_comb begin
    ax_nxt = DW'(a_x) - DW'(o_x);
    ay_nxt = DW'(a_y) - DW'(o_y);
    bx_nxt = DW'(b_x) - DW'(o_x);
    by_nxt = DW'(b_y) - DW'(o_y);
    dx_nxt = $signed({1'b0, 1'b0, p_x}) - DW'(o_x);
    dy_nxt = $signed({1'b0, 1'b0, p_y}) - DW'(o_y);
  end

  always_comb begin
    pd1_nxt = ax_r * by_r;
    pd2_nxt = ay_r * bx_r;
    pr1_nxt = dx_r * by_r;
    pr2_nxt = dy_r * bx_r;
    ps1_nxt = ax_r * dy_r;
    ps2_nxt = ay_r * dx_r;
  end

  always_comb begin
    den_nxt = NW'(pd1_r) - NW'(pd2_r);
    rn_nxt  = NW'(pr1_r) - NW'(pr2_r);
    sn_nxt  = NW'(ps1_r) - NW'(ps2_r);
  end

  always_comb begin
    if (den_r[NW-1]) begin
      denp_nxt = -den_r;
      rnp_nxt  = -rn_r;
      snp_nxt  = -sn_r;
    end else begin
      denp_nxt = den_r;
      rnp_nxt  = rn_r;
      snp_nxt  = sn_r;
    end
  end

  always_comb begin
    sum              = (NW+1)'(rnp_r) + (NW+1)'(snp_r);
    den_x            = (NW+1)'(denp_r);
    flags_nxt.den_nz = (denp_r != '0);
    flags_nxt.r_ok   = !rnp_r[NW-1] && (rnp_r <= denp_r);
    flags_nxt.s_ok   = !snp_r[NW-1] && (snp_r <= denp_r);
    flags_nxt.sum_lt = (sum < den_x);
    flags_nxt.sum_eq = (sum == den_x);
  end

  always_ff @(posedge clk) begin
    ax_r    <= ax_nxt;
    ay_r    <= ay_nxt;
    bx_r    <= bx_nxt;
    by_r    <= by_nxt;
    dx_r    <= dx_nxt;
    dy_r    <= dy_nxt;
    pd1_r   <= pd1_nxt;
    pd2_r   <= pd2_nxt;
    pr1_r   <= pr1_nxt;
    pr2_r   <= pr2_nxt;
    ps1_r   <= ps1_nxt;
    ps2_r   <= ps2_nxt;
    den_r   <= den_nxt;
    rn_r    <= rn_nxt;
    sn_r    <= sn_nxt;
    denp_r  <= denp_nxt;
    rnp_r   <= rnp_nxt;
    snp_r   <= snp_nxt;
    flags_r <= flags_nxt;
  end

  assign flags = flags_r;

endmodule

// ----- src/point_in_quad_test_core.sv -----
// ----------------------------------------------------------------------------
// point_in_quad_test_core
// Exact point-in-quad test over two triangles split on the c1-c4 diagonal.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive the four corners and the point on the in_ ports and
//   raise start; a beat is taken at every rising edge with start high and
//   busy low. busy is always low, so one beat can enter every cycle.
//   Result channel: out_valid is high for exactly one cycle per beat, with
//   out_inside_res set when the point lies in triangle (c3,c4,c1), edge r+s=1
//   excluded, or in triangle (c2,c1,c4), edge r+s=1 included.
//   Path: a beat passes the registers of the two triangle lanes (vectors,
//   products, numerators, sign fix, compares) and then the output register;
//   throughput one beat per cycle.
//   Reset: synchronous rst_n clears the valid pipe; no beat in flight
//   survives it. The receiver cannot stall: results leave as they finish.
// ----------------------------------------------------------------------------
module point_in_quad_test_core
  import pqt_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_corner1_x,
  input  logic signed [COORD_BITS-1:0] in_corner1_y,
  input  logic signed [COORD_BITS-1:0] in_corner2_x,
  input  logic signed [COORD_BITS-1:0] in_corner2_y,
  input  logic signed [COORD_BITS-1:0] in_corner3_x,
  input  logic signed [COORD_BITS-1:0] in_corner3_y,
  input  logic signed [COORD_BITS-1:0] in_corner4_x,
  input  logic signed [COORD_BITS-1:0] in_corner4_y,
  input  logic        [COORD_BITS-2:0] in_point_x,
  input  logic        [COORD_BITS-2:0] in_point_y,
  output logic                         out_valid,
  output logic                         out_inside_res
);

  pqt_flags_t          t1_flags, t2_flags;
  logic [PIPE_LAT-1:0] vld_r, vld_nxt;
  logic                res_r, res_nxt;
  logic                hit1, hit2;

  assign busy = 1'b0;

  // T1 = (c3, c4, c1): origin c3
  pqt_tri_lane #(.COORD_BITS(COORD_BITS)) u_lane_t1 (
    .clk   (clk),
    .o_x   (in_corner3_x),
    .o_y   (in_corner3_y),
    .a_x   (in_corner4_x),
    .a_y   (in_corner4_y),
    .b_x   (in_corner1_x),
    .b_y   (in_corner1_y),
    .p_x   (in_point_x),
    .p_y   (in_point_y),
    .flags (t1_flags)
  );

  // T2 = (c2, c1, c4): origin c2
  pqt_tri_lane #(.COORD_BITS(COORD_BITS)) u_lane_t2 (
    .clk   (clk),
    .o_x   (in_corner2_x),
    .o_y   (in_corner2_y),
    .a_x   (in_corner1_x),
    .a_y   (in_corner1_y),
    .b_x   (in_corner4_x),
    .b_y   (in_corner4_y),
    .p_x   (in_point_x),
    .p_y   (in_point_y),
    .flags (t2_flags)
  );

  always_comb begin
    hit1    = t1_flags.den_nz && t1_flags.r_ok && t1_flags.s_ok && t1_flags.sum_lt;
    hit2    = t2_flags.den_nz && t2_flags.r_ok && t2_flags.s_ok &&
              (t2_flags.sum_lt || t2_flags.sum_eq);
    res_nxt = hit1 || hit2;
    vld_nxt = {vld_r[PIPE_LAT-2:0], start && !busy};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid      = vld_r[PIPE_LAT-1];
  assign out_inside_res = res_r;

`ifndef SYNTH
  // a strobe only follows an accepted beat, exactly one latency earlier
  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, PIPE_LAT))
    else $error("result strobe without matching accepted beat");

  // zero denominator cannot pass the strict compares
  a_t1_degen: assert property (@(posedge clk)
    (t1_flags.r_ok && t1_flags.s_ok && t1_flags.sum_lt) |-> t1_flags.den_nz)
    else $error("T1 strict hit with zero denominator");

  a_t2_degen: assert property (@(posedge clk)
    (t2_flags.r_ok && t2_flags.s_ok && t2_flags.sum_lt) |-> t2_flags.den_nz)
    else $error("T2 strict hit with zero denominator");

  // both triangles degenerate: result must be outside
  a_both_degen: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[PIPE_LAT-2] && !t1_flags.den_nz && !t2_flags.den_nz)
      |=> (out_valid && !out_inside_res))
    else $error("hit reported for a fully degenerate quad");
`endif

endmodule
